[rtl/srfr_pkg.sv]
`timescale 1ns / 1ps

package srfr_pkg;

    localparam int FRAME_BUFFER_BYTES = 1024;
    localparam int USABLE_RAW = FRAME_BUFFER_BYTES - 8;
    localparam int USABLE_CAP = (USABLE_RAW > 1024) ? 1024 : USABLE_RAW;

    localparam logic [7:0]  HEAD_BYTE = 8'h40;
    localparam logic [7:0]  TAIL_BYTE = 8'h0D;

    localparam logic [15:0] TIMEOUT_RESET = 16'd200;
    localparam logic [10:0] LIMIT_RESET   = 11'd1004;
    localparam logic [10:0] LIMIT_CAP     = 11'(USABLE_CAP);

    typedef enum logic [1:0] {
        KIND_ARM  = 2'd0,
        KIND_BYTE = 2'd1,
        KIND_TICK = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_TIMEOUT_MS   = 2'd0,
        CFG_LENGTH_LIMIT = 2'd1,
        CFG_SPARE2       = 2'd2,
        CFG_SPARE3       = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HEAD    = 3'd1,
        PH_HEADER  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_SUM     = 3'd4,
        PH_XOR     = 3'd5,
        PH_TAIL    = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_T_HEAD   = 3'd1,
        ST_T_HEADER = 3'd2,
        ST_T_DATA   = 3'd3,
        ST_LENGTH   = 3'd4,
        ST_TAIL     = 3'd5,
        ST_SUM      = 3'd6,
        ST_XOR      = 3'd7
    } status_t;

endpackage

[rtl/serial_reply_frame_receiver.sv]
`timescale 1ns / 1ps

// Channel   Ports                          Direction  Contents
// s_        s_valid/s_ready                in         kind, rx_byte
// m_        m_valid/m_ready                out        payload byte or end-of-frame status
// cfg_      cfg_wr_en/cfg_index/cfg_wr_data in        timeout_ms (0), length_limit (1)
//
// One item per cycle while s_ready is high: each item is decoded in the cycle
// it is accepted and its result, if any, lands in the output register on the same edge.
// s_ready is high whenever the output register is empty or being drained, so
// a waiting result stalls the input only while m_ready is low.
// Reset (aresetn low, synchronous) returns to idle with default register values.
module serial_reply_frame_receiver (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [1:0]               cfg_index,
    input  logic [15:0]              cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_kind,
    input  logic [7:0]               s_rx_byte,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_result_kind,
    output logic [7:0]               m_payload_byte,
    output logic [9:0]               m_byte_index,
    output logic [2:0]               m_frame_status,
    output logic [7:0]               m_command_code,
    output logic [7:0]               m_reader_status,
    output logic [9:0]               m_payload_length,
    output logic                     m_last
);
    import srfr_pkg::*;

    logic [15:0] timeout_ms_reg;
    logic [10:0] length_limit_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [9:0]  count_reg, count_next;
    logic [15:0] length_reg, length_next;
    logic [7:0]  command_reg, command_next;
    logic [7:0]  rstat_reg, rstat_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  sum_rx_reg, sum_rx_next;
    logic [7:0]  xor_rx_reg, xor_rx_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic [9:0]  out_index_reg, out_index_next;
    status_t     out_status_reg, out_status_next;
    logic [7:0]  out_cmd_reg;
    logic [7:0]  out_rstat_reg;
    logic [9:0]  out_len_reg, out_len_next;
    logic        out_last_reg;

    logic        accept;
    kind_t       kind;
    logic [15:0] elapsed_inc;
    logic        timed_out;
    logic [15:0] length_full;
    logic [10:0] limit;
    logic        length_bad;
    logic [9:0]  count_inc;
    logic        finish;
    status_t     finish_status;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign kind    = kind_t'(s_kind);

    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign timed_out   = elapsed_inc >= timeout_ms_reg;
    assign length_full = {length_reg[15:8], s_rx_byte};
    assign limit       = (length_limit_reg < LIMIT_CAP) ? length_limit_reg : LIMIT_CAP;
    assign length_bad  = length_full >= {5'd0, limit};
    assign count_inc   = count_reg + 10'd1;

    // phase sequencing and frame end decision
    always_comb begin
        phase_next    = phase_reg;
        finish        = 1'b0;
        finish_status = ST_OK;
        if (accept) begin
            case (kind)
                KIND_ARM: begin
                    phase_next = PH_HEAD;
                end
                KIND_TICK: begin
                    if (phase_reg != PH_IDLE && timed_out) begin
                        finish = 1'b1;
                        case (phase_reg)
                            PH_HEAD:   finish_status = ST_T_HEAD;
                            PH_HEADER: finish_status = ST_T_HEADER;
                            default:   finish_status = ST_T_DATA;
                        endcase
                    end
                end
                KIND_BYTE: begin
                    case (phase_reg)
                        PH_HEAD: begin
                            if (s_rx_byte == HEAD_BYTE) begin
                                phase_next = PH_HEADER;
                            end
                        end
                        PH_HEADER: begin
                            if (count_reg == 10'd3) begin
                                if (length_bad) begin
                                    finish        = 1'b1;
                                    finish_status = ST_LENGTH;
                                end else if (length_full == 16'd0) begin
                                    phase_next = PH_SUM;
                                end else begin
                                    phase_next = PH_PAYLOAD;
                                end
                            end
                        end
                        PH_PAYLOAD: begin
                            if ({6'd0, count_inc} >= length_reg) begin
                                phase_next = PH_SUM;
                            end
                        end
                        PH_SUM: phase_next = PH_XOR;
                        PH_XOR: phase_next = PH_TAIL;
                        PH_TAIL: begin
                            finish = 1'b1;
                            if (s_rx_byte != TAIL_BYTE) begin
                                finish_status = ST_TAIL;
                            end else if (sum_rx_reg != sum_reg) begin
                                finish_status = ST_SUM;
                            end else if (xor_rx_reg != xor_reg) begin
                                finish_status = ST_XOR;
                            end else begin
                                finish_status = ST_OK;
                            end
                        end
                        default: phase_next = phase_reg;
                    endcase
                end
                default: phase_next = phase_reg;
            endcase
            if (finish) begin
                phase_next = PH_IDLE;
            end
        end
    end

    // frame datapath and result fields
    always_comb begin
        elapsed_next   = elapsed_reg;
        count_next     = count_reg;
        length_next    = length_reg;
        command_next   = command_reg;
        rstat_next     = rstat_reg;
        sum_next       = sum_reg;
        xor_next       = xor_reg;
        sum_rx_next    = sum_rx_reg;
        xor_rx_next    = xor_rx_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_kind_next  = 1'b1;
        out_byte_next  = 8'd0;
        out_index_next = count_reg;
        out_status_next = finish_status;
        if (accept) begin
            case (kind)
                KIND_ARM: begin
                    elapsed_next = 16'd0;
                    count_next   = 10'd0;
                    length_next  = 16'd0;
                    command_next = 8'd0;
                    rstat_next   = 8'd0;
                    sum_next     = 8'd0;
                    xor_next     = 8'd0;
                    sum_rx_next  = 8'd0;
                    xor_rx_next  = 8'd0;
                end
                KIND_TICK: begin
                    if (phase_reg != PH_IDLE) begin
                        elapsed_next = elapsed_inc;
                    end
                end
                KIND_BYTE: begin
                    case (phase_reg)
                        PH_HEAD: begin
                            if (s_rx_byte == HEAD_BYTE) begin
                                sum_next   = HEAD_BYTE;
                                xor_next   = HEAD_BYTE;
                                count_next = 10'd0;
                            end
                        end
                        PH_HEADER: begin
                            sum_next = sum_reg + s_rx_byte;
                            xor_next = xor_reg ^ s_rx_byte;
                            case (count_reg[1:0])
                                2'd0:    command_next = s_rx_byte;
                                2'd1:    rstat_next   = s_rx_byte;
                                2'd2:    length_next  = {s_rx_byte, 8'd0};
                                default: length_next  = length_full;
                            endcase
                            count_next = (count_reg == 10'd3) ? 10'd0 : count_inc;
                        end
                        PH_PAYLOAD: begin
                            sum_next       = sum_reg + s_rx_byte;
                            xor_next       = xor_reg ^ s_rx_byte;
                            count_next     = count_inc;
                            out_valid_next = 1'b1;
                            out_kind_next  = 1'b0;
                            out_byte_next  = s_rx_byte;
                            out_status_next = ST_OK;
                        end
                        PH_SUM:  sum_rx_next = s_rx_byte;
                        PH_XOR:  xor_rx_next = s_rx_byte;
                        default: count_next  = count_reg;
                    endcase
                end
                default: count_next = count_reg;
            endcase
            if (finish) begin
                out_valid_next = 1'b1;
            end
        end
        // a length error clears the header count, so its end result reports 0
        if (finish && kind == KIND_BYTE && phase_reg == PH_HEADER) begin
            out_index_next = 10'd0;
        end
        out_len_next = (length_next > 16'd1023) ? 10'd1023 : length_next[9:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_ms_reg   <= TIMEOUT_RESET;
            length_limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_TIMEOUT_MS:   timeout_ms_reg   <= cfg_wr_data;
                CFG_LENGTH_LIMIT: length_limit_reg <= cfg_wr_data[10:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            elapsed_reg   <= 16'd0;
            count_reg     <= 10'd0;
            length_reg    <= 16'd0;
            command_reg   <= 8'd0;
            rstat_reg     <= 8'd0;
            sum_reg       <= 8'd0;
            xor_reg       <= 8'd0;
            sum_rx_reg    <= 8'd0;
            xor_rx_reg    <= 8'd0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            count_reg     <= count_next;
            length_reg    <= length_next;
            command_reg   <= command_next;
            rstat_reg     <= rstat_next;
            sum_reg       <= sum_next;
            xor_reg       <= xor_next;
            sum_rx_reg    <= sum_rx_next;
            xor_rx_reg    <= xor_rx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded only when a new result is produced
    always_ff @(posedge aclk) begin
        if (accept && (finish || (kind == KIND_BYTE && phase_reg == PH_PAYLOAD))) begin
            out_kind_reg   <= out_kind_next;
            out_byte_reg   <= out_byte_next;
            out_index_reg  <= out_index_next;
            out_status_reg <= out_status_next;
            out_cmd_reg    <= command_next;
            out_rstat_reg  <= rstat_next;
            out_len_reg    <= out_len_next;
            out_last_reg   <= out_kind_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_result_kind    = out_kind_reg;
    assign m_payload_byte   = out_byte_reg;
    assign m_byte_index     = out_index_reg;
    assign m_frame_status   = out_status_reg;
    assign m_command_code   = out_cmd_reg;
    assign m_reader_status  = out_rstat_reg;
    assign m_payload_length = out_len_reg;
    assign m_last           = out_last_reg;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import srfr_pkg::*;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] payload_byte;
        logic [9:0] byte_index;
        status_t    frame_status;
        logic [7:0] command_code;
        logic [7:0] reader_status;
        logic [9:0] payload_length;
        logic       last;
    } frame_result_t;

    // One directed item; pinned rows carry the end status read straight off the spec.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       pinned;
        status_t    want;
    } stim_row_t;

    localparam int NUM_SETTINGS = 6;
    localparam int SET_TIMEOUT [NUM_SETTINGS] = '{65535, 3, 2, 0, 40, 200};
    localparam int SET_LIMIT   [NUM_SETTINGS] = '{1024, 1, 9, 2047, 0, 1004};
    localparam int SET_TICKS   [NUM_SETTINGS] = '{10, 10, 15, 6, 5, 3};
    localparam int ITEMS_PER_SETTING = 80;

    localparam stim_row_t DIRECTED_ROWS [27] = '{
        '{KIND_BYTE, HEAD_BYTE, 1'b0, ST_OK},   // idle: bytes, ticks and spare kind dropped
        '{KIND_TICK, 8'hFF,     1'b0, ST_OK},
        '{KIND_NONE, 8'hA5,     1'b0, ST_OK},
        '{KIND_ARM,  8'h00,     1'b0, ST_OK},
        '{KIND_TICK, 8'h00,     1'b1, ST_T_HEAD},
        '{KIND_ARM,  8'hFF,     1'b0, ST_OK},
        '{KIND_BYTE, 8'h00,     1'b0, ST_OK},
        '{KIND_BYTE, HEAD_BYTE, 1'b0, ST_OK},
        '{KIND_BYTE, 8'hFF,     1'b0, ST_OK},
        '{KIND_TICK, 8'h55,     1'b1, ST_T_HEADER},
        '{KIND_ARM,  8'h00,     1'b0, ST_OK},   // good frame, two payload bytes
        '{KIND_BYTE, HEAD_BYTE, 1'b0, ST_OK},
        '{KIND_BYTE, 8'hFF,     1'b0, ST_OK},
        '{KIND_BYTE, 8'h00,     1'b0, ST_OK},
        '{KIND_BYTE, 8'h00,     1'b0, ST_OK},
        '{KIND_BYTE, 8'h02,     1'b0, ST_OK},
        '{KIND_BYTE, 8'hFF,     1'b0, ST_OK},
        '{KIND_BYTE, 8'h00,     1'b0, ST_OK},
        '{KIND_BYTE, 8'h40,     1'b0, ST_OK},
        '{KIND_BYTE, 8'h42,     1'b0, ST_OK},
        '{KIND_BYTE, TAIL_BYTE, 1'b1, ST_OK},
        '{KIND_ARM,  8'h00,     1'b0, ST_OK},   // declared length 0xFFFF
        '{KIND_BYTE, HEAD_BYTE, 1'b0, ST_OK},
        '{KIND_BYTE, 8'h00,     1'b0, ST_OK},
        '{KIND_BYTE, 8'h00,     1'b0, ST_OK},
        '{KIND_BYTE, 8'hFF,     1'b0, ST_OK},
        '{KIND_BYTE, 8'hFF,     1'b1, ST_LENGTH}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CFG_TIMEOUT_MS;
    logic [15:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = KIND_NONE;
    logic [7:0]  s_rx_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_result_kind;
    logic [7:0]  m_payload_byte;
    logic [9:0]  m_byte_index;
    logic [2:0]  m_frame_status;
    logic [7:0]  m_command_code;
    logic [7:0]  m_reader_status;
    logic [9:0]  m_payload_length;
    logic        m_last;

    // side band that travels with the item
    logic        tag_pinned = 1'b0;
    status_t     tag_status = ST_OK;

    int          src_gap_pct = 0;
    int          sink_gap_pct = 0;
    int unsigned items_pushed = 0;
    int unsigned fail_count = 0;
    int unsigned bytes_checked = 0;
    int unsigned ends_checked = 0;
    logic [7:0]  status_seen = '0;

    frame_result_t pending_replies[$];

    // receiver model state
    phase_t      rx_phase;
    logic [15:0] ms_elapsed;
    logic [9:0]  count;
    logic [15:0] declared_len;
    logic [7:0]  cmd_held;
    logic [7:0]  rdr_held;
    logic [7:0]  sum_acc;
    logic [7:0]  xor_acc;
    logic [7:0]  sum_got;
    logic [7:0]  xor_got;
    logic [15:0] timeout_cfg;
    logic [10:0] limit_cfg;

    serial_reply_frame_receiver u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_payload_byte   (m_payload_byte),
        .m_byte_index     (m_byte_index),
        .m_frame_status   (m_frame_status),
        .m_command_code   (m_command_code),
        .m_reader_status  (m_reader_status),
        .m_payload_length (m_payload_length),
        .m_last           (m_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic void clear_frame();
        ms_elapsed = '0;
        count = '0;
        declared_len = '0;
        cmd_held = '0;
        rdr_held = '0;
        sum_acc = '0;
        xor_acc = '0;
        sum_got = '0;
        xor_got = '0;
    endfunction

    function automatic frame_result_t report(input logic rk, input logic [7:0] pb,
                                             input logic [9:0] idx, input status_t st);
        frame_result_t r;
        r.result_kind = rk;
        r.payload_byte = pb;
        r.byte_index = idx;
        r.frame_status = st;
        r.command_code = cmd_held;
        r.reader_status = rdr_held;
        r.payload_length = (declared_len > 16'd1023) ? 10'd1023 : declared_len[9:0];
        r.last = rk;
        return r;
    endfunction

    function automatic frame_result_t end_frame(input status_t st);
        rx_phase = PH_IDLE;
        return report(1'b1, 8'h00, count, st);
    endfunction

    task automatic frame_step(input kind_t k, input logic [7:0] b,
                              output logic has, output frame_result_t r);
        int unsigned lim;
        status_t     st;
        has = 1'b0;
        r = '0;
        if (k == KIND_ARM) begin
            clear_frame();
            rx_phase = PH_HEAD;
        end else if (k == KIND_NONE || rx_phase == PH_IDLE) begin
            // nothing to do
        end else if (k == KIND_TICK) begin
            if (ms_elapsed != 16'hFFFF) ms_elapsed++;
            if (ms_elapsed >= timeout_cfg) begin
                if (rx_phase == PH_HEAD) st = ST_T_HEAD;
                else if (rx_phase == PH_HEADER) st = ST_T_HEADER;
                else st = ST_T_DATA;
                has = 1'b1;
                r = end_frame(st);
            end
        end else begin
            case (rx_phase)
                PH_HEAD: begin
                    if (b == HEAD_BYTE) begin
                        sum_acc = HEAD_BYTE;
                        xor_acc = HEAD_BYTE;
                        count = '0;
                        rx_phase = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    sum_acc += b;
                    xor_acc ^= b;
                    // header order: command, reader status, length high, length low
                    case (count)
                        10'd0: cmd_held = b;
                        10'd1: rdr_held = b;
                        10'd2: declared_len = {b, 8'h00};
                        default: declared_len = declared_len | {8'h00, b};
                    endcase
                    count++;
                    if (count >= 10'd4) begin
                        lim = (limit_cfg < LIMIT_CAP) ? limit_cfg : LIMIT_CAP;
                        count = '0;
                        if (declared_len >= lim) begin
                            has = 1'b1;
                            r = end_frame(ST_LENGTH);
                        end else if (declared_len == 16'd0) begin
                            rx_phase = PH_SUM;
                        end else begin
                            rx_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    sum_acc += b;
                    xor_acc ^= b;
                    has = 1'b1;
                    r = report(1'b0, b, count, ST_OK);
                    count++;
                    if (count >= declared_len) rx_phase = PH_SUM;
                end
                PH_SUM: begin
                    sum_got = b;
                    rx_phase = PH_XOR;
                end
                PH_XOR: begin
                    xor_got = b;
                    rx_phase = PH_TAIL;
                end
                PH_TAIL: begin
                    if (b != TAIL_BYTE) st = ST_TAIL;
                    else if (sum_got != sum_acc) st = ST_SUM;
                    else if (xor_got != xor_acc) st = ST_XOR;
                    else st = ST_OK;
                    has = 1'b1;
                    r = end_frame(st);
                end
                default: rx_phase = PH_IDLE;
            endcase
        end
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t ERROR %s: expected 0x%0h, got 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        logic          has;
        frame_result_t r;
        frame_result_t want;
        if (!aresetn) begin
            timeout_cfg = TIMEOUT_RESET;
            limit_cfg = LIMIT_RESET;
            rx_phase = PH_IDLE;
            clear_frame();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_TIMEOUT_MS:   timeout_cfg = cfg_wr_data;
                    CFG_LENGTH_LIMIT: limit_cfg = cfg_wr_data[10:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                frame_step(kind_t'(s_kind), s_rx_byte, has, r);
                if (tag_pinned) begin
                    has = 1'b1;
                    r.result_kind = 1'b1;
                    r.last = 1'b1;
                    r.payload_byte = 8'h00;
                    r.frame_status = tag_status;
                end
                if (has) pending_replies.push_back(r);
            end
            if (m_valid && m_ready) begin
                if (pending_replies.size() == 0) begin
                    $display("%0t ERROR result with nothing expected: last=%0b status=%0d",
                             $time, m_last, m_frame_status);
                    fail_count++;
                end else begin
                    want = pending_replies.pop_front();
                    check_field("result_kind", want.result_kind, m_result_kind);
                    check_field("payload_byte", want.payload_byte, m_payload_byte);
                    check_field("byte_index", want.byte_index, m_byte_index);
                    check_field("frame_status", want.frame_status, m_frame_status);
                    check_field("command_code", want.command_code, m_command_code);
                    check_field("reader_status", want.reader_status, m_reader_status);
                    check_field("payload_length", want.payload_length, m_payload_length);
                    check_field("last", want.last, m_last);
                    if (want.last) begin
                        ends_checked++;
                        status_seen[want.frame_status] = 1'b1;
                    end else begin
                        bytes_checked++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_gap_pct);
        end
    end

    task automatic push_item(input kind_t k, input logic [7:0] b, input logic pin,
                             input status_t want);
        while ($urandom_range(99) < src_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= k;
        s_rx_byte <= b;
        tag_pinned <= pin;
        tag_status <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_pushed++;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_replies.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(posedge aclk);
    endtask

    // ticks and spare-kind items sprinkled between frame bytes
    task automatic line_noise(input int tick_pct);
        while ($urandom_range(99) < tick_pct)
            push_item(KIND_TICK, 8'($urandom), 1'b0, ST_OK);
        if ($urandom_range(99) < 3)
            push_item(KIND_NONE, 8'($urandom), 1'b0, ST_OK);
    endtask

    task automatic send_frame(input int tick_pct, input int unsigned lim);
        logic [7:0]  frame_q[$];
        logic [7:0]  b;
        logic [7:0]  sum_tx;
        logic [7:0]  xor_tx;
        logic [7:0]  tail_tx;
        int unsigned len;
        int          pick;
        int          cut;
        frame_q = {};
        pick = $urandom_range(99);
        if (lim == 0 || pick < 8) len = lim;
        else if (pick < 16) len = $urandom_range(65535, lim);
        else if (pick < 26) len = (lim - 1 > 48) ? $urandom_range(48, 7) : lim - 1;
        else len = $urandom_range((lim - 1 > 6) ? 6 : lim - 1, 0);

        repeat ($urandom_range(2)) begin
            b = 8'($urandom);
            if (b == HEAD_BYTE) b ^= 8'h80;
            frame_q.push_back(b);
        end
        frame_q.push_back(HEAD_BYTE);
        frame_q.push_back(8'($urandom));
        frame_q.push_back(8'($urandom));
        frame_q.push_back(len[15:8]);
        frame_q.push_back(len[7:0]);
        sum_tx = HEAD_BYTE;
        xor_tx = HEAD_BYTE;
        for (int i = frame_q.size() - 4; i < frame_q.size(); i++) begin
            sum_tx += frame_q[i];
            xor_tx ^= frame_q[i];
        end
        if (len < lim) begin
            repeat (len) begin
                b = 8'($urandom);
                sum_tx += b;
                xor_tx ^= b;
                frame_q.push_back(b);
            end
            tail_tx = TAIL_BYTE;
            pick = $urandom_range(99);
            if (pick < 7) tail_tx ^= 8'($urandom_range(255, 1));
            else if (pick < 14) sum_tx ^= 8'($urandom_range(255, 1));
            else if (pick < 21) xor_tx ^= 8'($urandom_range(255, 1));
            else if (pick < 25) begin
                sum_tx ^= 8'($urandom_range(255, 1));
                xor_tx ^= 8'($urandom_range(255, 1));
            end
            frame_q.push_back(sum_tx);
            frame_q.push_back(xor_tx);
            frame_q.push_back(tail_tx);
        end
        // occasionally cut the frame short so the next arm lands mid-frame
        if ($urandom_range(99) < 6) begin
            cut = $urandom_range(frame_q.size() - 1, 1);
            repeat (cut) void'(frame_q.pop_back());
        end

        push_item(KIND_ARM, 8'($urandom), 1'b0, ST_OK);
        foreach (frame_q[i]) begin
            line_noise(tick_pct);
            push_item(KIND_BYTE, frame_q[i], 1'b0, ST_OK);
        end
    endtask

    initial begin
        int          i;
        int          s;
        int unsigned target;
        int unsigned lim;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_gap_pct = 28;
        sink_gap_pct = 62;
        write_reg(CFG_TIMEOUT_MS, 16'd1);
        for (i = 0; i < $size(DIRECTED_ROWS); i++)
            push_item(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].data,
                      DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].want);
        drain_results();

        for (s = 0; s < NUM_SETTINGS; s++) begin
            src_gap_pct = (s < 2) ? 28 : (s < 4) ? 62 : 0;
            sink_gap_pct = (s < 2) ? 62 : (s < 4) ? 28 : 0;
            write_reg(CFG_TIMEOUT_MS, 16'(SET_TIMEOUT[s]));
            write_reg(CFG_LENGTH_LIMIT, 16'(SET_LIMIT[s]));
            if (s == 2) begin
                // spare indexes must not disturb either register
                write_reg(CFG_SPARE2, 16'($urandom));
                write_reg(CFG_SPARE3, 16'hFFFF);
            end
            lim = (SET_LIMIT[s] < LIMIT_CAP) ? SET_LIMIT[s] : LIMIT_CAP;
            target = items_pushed + ITEMS_PER_SETTING;
            while (items_pushed < target)
                send_frame(SET_TICKS[s], lim);
            drain_results();
        end

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        if (pending_replies.size() != 0) begin
            $display("%0t ERROR %0d expected results never arrived", $time,
                     pending_replies.size());
            fail_count++;
        end
        $display("Ran %0d items over %0d register settings: %0d payload bytes, %0d frame ends",
                 items_pushed, NUM_SETTINGS + 1, bytes_checked, ends_checked);
        $display("End statuses observed, one bit per code (7..0): %b", status_seen);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t ERROR run did not finish in time", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
